// ===== src/cig_pkg.sv =====
// Shared constants, types and the case-folding function for the glob matcher.
// Used by cig_cell and by case_insensitive_glob_matcher_unit.
package cig_pkg;

    localparam int PAT_MAX = 64;
    localparam int LEN_W   = $clog2(PAT_MAX + 1);

    localparam logic [7:0] STAR_CODE  = 8'd42;
    localparam logic [7:0] QMARK_CODE = 8'd63;
    localparam logic [7:0] UPPER_A    = 8'd65;
    localparam logic [7:0] UPPER_Z    = 8'd90;
    localparam logic [7:0] CASE_GAP   = 8'd32;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_NAME    = 1'b1;

    // Control broadcast from the top level to every cell of the row.
    typedef struct packed {
        logic             step;       // a name byte is accepted this cycle
        logic             starting;   // this name byte opens a new name
        logic             wild;       // pattern holds a star or a question mark
        logic [7:0]       fc;         // folded name byte
        logic [LEN_W-1:0] len;        // pattern length
        logic [LEN_W-1:0] lead;       // number of leading stars
        logic             load;       // a pattern byte is stored this cycle
        logic [LEN_W-1:0] load_idx;
        logic [7:0]       load_byte;
    } t_cell_ctl;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[UPPER_A:UPPER_Z]}) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

endpackage

// ===== src/cig_cell.sv =====
// One pattern position of the matcher row: holds a pattern byte and its active bit.
// Depends on cig_pkg; hands advance and star-closure bits to the next cell.
module cig_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [cig_pkg::LEN_W-1:0] i_index,
    input  cig_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_adv,
    input  logic                      i_carry,
    output logic                      o_adv,
    output logic                      o_carry,
    output logic                      o_next
);

    logic [7:0] r_byte;
    logic       r_act;

    logic in_range;
    logic act_eff;
    logic is_star;
    logic fold_eq;
    logic chr_match;
    logic sticky;
    logic n_act;

    always_comb begin
        in_range = i_index < i_ctl.len;
        // At the start of a name only the leading run of stars and the position after it are live.
        act_eff  = i_ctl.starting ? (i_ctl.wild && (i_index <= i_ctl.lead)) : r_act;
        is_star  = r_byte == cig_pkg::STAR_CODE;
        fold_eq  = cig_pkg::fold_byte(r_byte) == i_ctl.fc;
        chr_match = (r_byte == cig_pkg::QMARK_CODE) || fold_eq;

        if (i_ctl.wild) begin
            o_adv = in_range && act_eff && !is_star && chr_match;
        end else begin
            o_adv = in_range && (act_eff || (i_index == '0)) && fold_eq;
        end

        // In substring mode the position after the pattern keeps its hit.
        sticky = !i_ctl.wild && (i_index == i_ctl.len) && (i_index != '0) && act_eff;
        n_act  = i_adv || i_carry || (i_ctl.wild && in_range && act_eff && is_star) || sticky;
        o_carry = i_ctl.wild && in_range && is_star && n_act;
        o_next  = n_act;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_ctl.load_idx == i_index)) begin
            r_byte <= i_ctl.load_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_ctl.step) begin
            r_act <= n_act;
        end
    end

endmodule

// ===== src/case_insensitive_glob_matcher_unit.sv =====
// Top level of the case-insensitive glob matcher: pattern bookkeeping, the cell row
// and a two-entry result buffer; depends on cig_pkg and cig_cell.
// The verdict of a name's last byte is registered in the head entry, or the skid entry.
// Throughput: one pattern or name byte per cycle; input stalls only while both result
// entries are held. Star runs ripple along the cell chain within that cycle.
// Reset (synchronous, active low) clears lengths, flags, active bits and the buffer.
module case_insensitive_glob_matcher_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_mode,
    input  logic [7:0] i_char_code,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_matched,
    output logic       o_pattern_too_long
);

    localparam int PM = cig_pkg::PAT_MAX;
    localparam int LW = cig_pkg::LEN_W;

    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_lead, n_lead;
    logic          r_wild, n_wild;
    logic          r_ovf, n_ovf;
    logic          r_all_star, n_all_star;
    logic          r_complete, n_complete;
    logic          r_starting, n_starting;
    logic          r_top_act;

    logic          r_out_v, r_skid_v;
    logic          r_out_m, r_out_e, r_skid_m, r_skid_e;

    logic          acc, pat_acc, name_acc, push, pop;
    logic [LW-1:0] fill_len, base_lead;
    logic          base_wild, base_all_star, is_star, is_q, store;
    logic          top_eff, top_next, res_m;

    cig_pkg::t_cell_ctl ctl;
    logic [PM:0]   adv_chain;
    logic [PM:0]   carry_chain;
    logic [PM:0]   next_vec;

    assign o_in_ready = !r_skid_v;
    assign acc      = i_in_valid && o_in_ready;
    assign pat_acc  = acc && (i_mode == cig_pkg::MODE_PATTERN);
    assign name_acc = acc && (i_mode == cig_pkg::MODE_NAME);

    always_comb begin
        fill_len      = r_complete ? '0 : r_len;
        base_lead     = r_complete ? '0 : r_lead;
        base_wild     = r_complete ? 1'b0 : r_wild;
        base_all_star = r_complete ? 1'b1 : r_all_star;
        is_star       = i_char_code == cig_pkg::STAR_CODE;
        is_q          = i_char_code == cig_pkg::QMARK_CODE;
        store         = fill_len < LW'(PM);

        n_len      = r_len;
        n_lead     = r_lead;
        n_wild     = r_wild;
        n_ovf      = r_ovf;
        n_all_star = r_all_star;
        n_complete = r_complete;
        n_starting = r_starting;
        if (pat_acc) begin
            n_len      = fill_len;
            n_lead     = base_lead;
            n_wild     = base_wild;
            n_ovf      = r_complete ? 1'b0 : r_ovf;
            n_all_star = base_all_star;
            if (store) begin
                n_len  = fill_len + LW'(1);
                n_wild = base_wild || is_star || is_q;
                if (base_all_star && is_star) begin
                    n_lead = base_lead + LW'(1);
                end else begin
                    n_all_star = 1'b0;
                end
            end else begin
                n_ovf = 1'b1;
            end
            n_complete = i_last;
            n_starting = 1'b1;
        end else if (name_acc) begin
            n_starting = i_last;
        end
    end

    always_comb begin
        ctl.step      = name_acc;
        ctl.starting  = r_starting;
        ctl.wild      = r_wild;
        ctl.fc        = cig_pkg::fold_byte(i_char_code);
        ctl.len       = r_len;
        ctl.lead      = r_lead;
        ctl.load      = pat_acc && store;
        ctl.load_idx  = fill_len;
        ctl.load_byte = i_char_code;
    end

    assign adv_chain[0]   = 1'b0;
    assign carry_chain[0] = 1'b0;

    for (genvar k = 0; k < PM; k++) begin : g_cell
        cig_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (LW'(k)),
            .i_ctl   (ctl),
            .i_adv   (adv_chain[k]),
            .i_carry (carry_chain[k]),
            .o_adv   (adv_chain[k+1]),
            .o_carry (carry_chain[k+1]),
            .o_next  (next_vec[k])
        );
    end

    // Position after a full-length pattern has no byte of its own.
    always_comb begin
        top_eff  = r_starting ? (r_wild && (r_lead == LW'(PM))) : r_top_act;
        top_next = adv_chain[PM] || carry_chain[PM]
                   || (!r_wild && (r_len == LW'(PM)) && top_eff);
    end

    assign next_vec[PM] = top_next;
    assign res_m = !r_ovf && (r_len != '0) && next_vec[r_len];

    assign push = name_acc && i_last;
    assign pop  = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_lead     <= '0;
            r_wild     <= 1'b0;
            r_ovf      <= 1'b0;
            r_all_star <= 1'b1;
            r_complete <= 1'b1;
            r_starting <= 1'b1;
            r_top_act  <= 1'b0;
            r_out_v    <= 1'b0;
            r_skid_v   <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_lead     <= n_lead;
            r_wild     <= n_wild;
            r_ovf      <= n_ovf;
            r_all_star <= n_all_star;
            r_complete <= n_complete;
            r_starting <= n_starting;
            if (name_acc) begin
                r_top_act <= top_next;
            end
            if (r_skid_v) begin
                if (pop) begin
                    r_skid_v <= 1'b0;
                end
            end else if (push && r_out_v && !pop) begin
                r_skid_v <= 1'b1;
            end else if (push) begin
                r_out_v <= 1'b1;
            end else if (pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Result payload; the skid entry moves up when the head request is taken.
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_out_m <= r_skid_m;
                r_out_e <= r_skid_e;
            end
        end else if (push && (!r_out_v || pop)) begin
            r_out_m <= res_m;
            r_out_e <= r_ovf;
        end else if (push) begin
            r_skid_m <= res_m;
            r_skid_e <= r_ovf;
        end
    end

    assign o_out_valid        = r_out_v;
    assign o_matched          = r_out_m;
    assign o_pattern_too_long = r_out_e;

    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without a head entry");

    a_overflow_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pattern_too_long) |-> !o_matched)
        else $error("match reported with an overlong pattern");

    a_lead_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead <= r_len)
        else $error("leading star count exceeds pattern length");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LW'(PM)))
        else $error("overflow flagged below full length");

    a_pattern_restarts_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pat_acc |=> r_starting)
        else $error("pattern byte did not abandon the current name");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for case_insensitive_glob_matcher_unit: pattern and name requests,
// a behavioral match predictor and a scoreboard of expected verdicts.
// Depends on cig_pkg for the port constants and on the matcher RTL.
module tb;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic matched;
        logic too_long;
    } t_verdict;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_SLOW} t_rx_style;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_mode      = cig_pkg::MODE_PATTERN;
    logic [7:0] i_char_code = 8'h00;
    logic       i_last      = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_matched;
    logic       o_pattern_too_long;

    case_insensitive_glob_matcher_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_char_code        (i_char_code),
        .i_last             (i_last),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_matched          (o_matched),
        .o_pattern_too_long (o_pattern_too_long)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state: the loaded pattern and the set of live pattern positions.
    logic [7:0]                pat_mem [cig_pkg::PAT_MAX];
    int                        pat_len    = 0;
    bit                        pat_wild   = 1'b0;
    bit                        pat_ovf    = 1'b0;
    bit                        pat_done   = 1'b1;
    bit                        name_fresh = 1'b1;
    logic [cig_pkg::PAT_MAX:0] live       = '0;

    t_verdict    verdict_q [$];
    logic [7:0]  pat_bytes [$];
    logic [7:0]  name_bytes [$];
    int          errors     = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int unsigned cycle_cnt  = 0;
    logic [7:0]  rx_cnt     = '0;
    t_rx_style   rx_style   = RX_OPEN;

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // A live position that holds a star also makes the one behind it live;
    // the ascending walk carries this through runs of stars.
    function automatic logic [cig_pkg::PAT_MAX:0] close_stars(
        input logic [cig_pkg::PAT_MAX:0] s, input int len);
        logic [cig_pkg::PAT_MAX:0] r;
        r = s;
        for (int i = 0; i < len; i++) begin
            if (r[i] && pat_mem[i] == cig_pkg::STAR_CODE) r[i+1] = 1'b1;
        end
        return r;
    endfunction

    task automatic advance_match_state(input logic mode, input logic [7:0] c, input logic fin,
                                       output bit has_verdict, output t_verdict v);
        int                        len;
        logic [cig_pkg::PAT_MAX:0] nxt;
        logic [7:0]                fc;
        has_verdict = 1'b0;
        v = '0;
        if (mode == cig_pkg::MODE_PATTERN) begin
            if (pat_done) begin
                pat_len  = 0;
                pat_wild = 1'b0;
                pat_ovf  = 1'b0;
                pat_done = 1'b0;
            end
            if (pat_len < cig_pkg::PAT_MAX) begin
                pat_mem[pat_len] = c;
                pat_len++;
                if (c == cig_pkg::STAR_CODE || c == cig_pkg::QMARK_CODE) pat_wild = 1'b1;
            end else begin
                pat_ovf = 1'b1;
            end
            if (fin) pat_done = 1'b1;
            name_fresh = 1'b1;
        end else begin
            len = pat_len;
            if (name_fresh) begin
                live = '0;
                if (pat_wild) begin
                    live[0] = 1'b1;
                    live = close_stars(live, len);
                end
                name_fresh = 1'b0;
            end
            fc  = lower_case(c);
            nxt = '0;
            if (pat_wild) begin
                for (int i = 0; i < len; i++) begin
                    if (live[i]) begin
                        if (pat_mem[i] == cig_pkg::STAR_CODE) nxt[i] = 1'b1;
                        else if (pat_mem[i] == cig_pkg::QMARK_CODE
                                 || lower_case(pat_mem[i]) == fc)
                            nxt[i+1] = 1'b1;
                    end
                end
                nxt = close_stars(nxt, len);
            end else if (len > 0) begin
                // Substring search: position zero is always live, and the end
                // position latches once the pattern has been seen.
                for (int i = 0; i < len; i++) begin
                    if ((live[i] || i == 0) && lower_case(pat_mem[i]) == fc) nxt[i+1] = 1'b1;
                end
                if (live[len]) nxt[len] = 1'b1;
            end
            live = nxt;
            if (fin) begin
                has_verdict = 1'b1;
                v.matched   = !pat_ovf && len > 0 && live[len];
                v.too_long  = pat_ovf;
                name_fresh  = 1'b1;
            end
        end
    endtask

    // Sends one request; returns in the time step of its acceptance with valid still high.
    task automatic send_req(input logic mode, input logic [7:0] c, input logic fin);
        bit       hv;
        t_verdict v;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_char_code <= c;
        i_last      <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        advance_match_state(mode, c, fin, hv, v);
        if (hv) verdict_q.push_back(v);
        items_sent++;
    endtask

    task automatic send_pattern(input bit with_last);
        for (int i = 0; i < pat_bytes.size(); i++)
            send_req(cig_pkg::MODE_PATTERN, pat_bytes[i],
                     with_last && i == pat_bytes.size() - 1);
    endtask

    task automatic send_name();
        for (int i = 0; i < name_bytes.size(); i++)
            send_req(cig_pkg::MODE_NAME, name_bytes[i], i == name_bytes.size() - 1);
    endtask

    task automatic set_pattern_text(input string s);
        pat_bytes.delete();
        for (int i = 0; i < s.len(); i++) pat_bytes.push_back(s[i]);
    endtask

    task automatic set_name_text(input string s);
        name_bytes.delete();
        for (int i = 0; i < s.len(); i++) name_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_char();
        string alpha;
        alpha = "aAbBzZ.0";
        if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        return alpha[$urandom_range(0, 7)];
    endfunction

    function automatic logic [7:0] pick_glob_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return cig_pkg::STAR_CODE;
        if (r < 35) return cig_pkg::QMARK_CODE;
        return pick_char();
    endfunction

    // Builds a name that fits the current pattern, then sometimes spoils it.
    task automatic build_name(input bit wild);
        logic [7:0] c;
        bit         pad;
        name_bytes.delete();
        pad = ($urandom_range(0, 99) < 60) || !wild;
        if (pad) repeat ($urandom_range(0, 3)) name_bytes.push_back(pick_char());
        foreach (pat_bytes[i]) begin
            c = pat_bytes[i];
            if (c == cig_pkg::STAR_CODE) begin
                repeat ($urandom_range(0, 3)) name_bytes.push_back(pick_char());
            end else if (c == cig_pkg::QMARK_CODE) begin
                name_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                if (is_letter(c) && $urandom_range(0, 1)) c = c ^ 8'h20;
                name_bytes.push_back(c);
            end
        end
        if (pad) repeat ($urandom_range(0, 3)) name_bytes.push_back(pick_char());
        if (name_bytes.size() == 0) name_bytes.push_back(pick_char());
        if ($urandom_range(0, 3) == 0)
            name_bytes[$urandom_range(0, name_bytes.size() - 1)] = pick_char();
    endtask

    task automatic test_empty_pattern();
        set_name_text("Z");
        send_name();
        name_bytes = '{8'h00, 8'hFF};
        send_name();
    endtask

    task automatic test_substring();
        set_pattern_text("aBc");
        send_pattern(1'b1);
        set_name_text("xxABCy");
        send_name();
        set_name_text("ab");
        send_name();
        set_name_text("zabc");
        send_name();
    endtask

    task automatic test_glob();
        set_pattern_text("*.T?T");
        send_pattern(1'b1);
        set_name_text("Read.txt");
        send_name();
        set_name_text("a.tx");
        send_name();
        set_pattern_text("a**b");
        send_pattern(1'b1);
        set_name_text("AB");
        send_name();
        set_name_text("ba");
        send_name();
    endtask

    task automatic test_zero_bytes();
        pat_bytes = '{8'h00, cig_pkg::QMARK_CODE};
        send_pattern(1'b1);
        name_bytes = '{8'h00, 8'hFF};
        send_name();
        name_bytes = '{8'h00};
        send_name();
    endtask

    // Names against an unfinished pattern, and a pattern request cutting a name short.
    task automatic test_partial_pattern();
        set_pattern_text("x*");
        send_pattern(1'b0);
        set_name_text("XYZ");
        send_name();
        send_req(cig_pkg::MODE_NAME, "x", 1'b0);
        send_req(cig_pkg::MODE_PATTERN, "q", 1'b1);
        set_name_text("xaQ");
        send_name();
    endtask

    task automatic test_overflow();
        pat_bytes.delete();
        repeat (cig_pkg::PAT_MAX + 2) pat_bytes.push_back("a");
        send_pattern(1'b1);
        set_name_text("a");
        send_name();
        pat_bytes = '{"a"};
        send_pattern(1'b1);
        set_name_text("A");
        send_name();
    endtask

    task automatic test_random_traffic();
        int start;
        int kind;
        int len;
        int split;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 40)      len = $urandom_range(1, 6);
            else if (kind < 85) len = $urandom_range(1, 8);
            else if (kind < 94) len = $urandom_range(20, cig_pkg::PAT_MAX);
            else                len = $urandom_range(cig_pkg::PAT_MAX + 1, cig_pkg::PAT_MAX + 6);
            pat_bytes.delete();
            repeat (len) pat_bytes.push_back(kind < 40 ? pick_char() : pick_glob_char());
            // Generate the name against the full pattern, treated as a glob,
            // before any of it is loaded.
            build_name(1'b1);
            split = ($urandom_range(0, 9) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
            for (int i = 0; i < len; i++) begin
                if (split != 0 && i == split) send_name();
                send_req(cig_pkg::MODE_PATTERN, pat_bytes[i], i == len - 1);
            end
            repeat ($urandom_range(1, 5)) begin
                build_name(pat_wild);
                if ($urandom_range(0, 11) == 0) begin
                    for (int i = 0; i < name_bytes.size() - 1; i++)
                        send_req(cig_pkg::MODE_NAME, name_bytes[i], 1'b0);
                    send_req(cig_pkg::MODE_PATTERN, pick_glob_char(),
                             $urandom_range(0, 3) != 0);
                end else begin
                    send_name();
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_pattern();
        test_substring();
        test_glob();
        test_zero_bytes();
        test_partial_pattern();
        test_overflow();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // The receiver cycles through several stall styles of its own.
    always @(posedge i_clk) begin
        rx_cnt <= rx_cnt + 8'd1;
        if (rx_cnt[5:0] == 6'd0) rx_style <= t_rx_style'($urandom_range(0, 3));
        case (rx_style)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:   i_out_ready <= (rx_cnt[3:0] < 4'd3);
        endcase
    end

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual matched=%0b too_long=%0b",
                         $time, o_matched, o_pattern_too_long);
                errors++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (o_matched !== exp_v.matched) begin
                    $display("%0t: matched mismatch, expected %0b, actual %0b",
                             $time, exp_v.matched, o_matched);
                    errors++;
                end
                if (o_pattern_too_long !== exp_v.too_long) begin
                    $display("%0t: pattern_too_long mismatch, expected %0b, actual %0b",
                             $time, exp_v.too_long, o_pattern_too_long);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
